>>> design/record_merge_sorter_macros.svh
// Assertion macros shared by the record merge sorter modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RECORD_MERGE_SORTER_MACROS_SVH
`define RECORD_MERGE_SORTER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the same cycle.
`define RMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rms_pkg.sv
// Package for the record merge sorter: field widths, default sizes and
// the control word that steers the row of sorting cells. No dependencies.
package rms_pkg;

    // Fixed field widths of one record.
    localparam int RANK_W = 5;
    localparam int NAME_W = 64;
    localparam int POS_W  = 32;
    localparam int IDX_W  = 10;

    // Default sizes.
    localparam int DEF_MAX_RECORDS = 1024;
    localparam int DEF_NAME_BYTES  = 8;
    localparam int DEF_NAME_BITS   = 8 * DEF_NAME_BYTES;
    localparam int DEF_KEY_W       = RANK_W + DEF_NAME_BITS + POS_W;
    localparam int DEF_REC_W       = DEF_KEY_W + IDX_W;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic insert;   // place the new record in key order
        logic rotate;   // shift one place towards the head, head wraps to the tail
    } cell_ctrl_t;

endpackage

>>> design/rms_cell.sv
// One sorting cell: holds a single record and its valid bit.
// Depends on rms_pkg for the cell control word.
module rms_cell
    import rms_pkg::*;
#(
    parameter int REC_W = DEF_REC_W,
    parameter int KEY_W = DEF_KEY_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [REC_W-1:0] new_rec,
    input  logic [REC_W-1:0] head_rec,
    input  logic [REC_W-1:0] left_rec,
    input  logic             left_valid,
    input  logic             left_lt,
    input  logic [REC_W-1:0] right_rec,
    input  logic             right_valid,
    output logic [REC_W-1:0] rec,
    output logic             valid,
    output logic             lt
);

    logic [REC_W-1:0] rec_reg;
    logic [REC_W-1:0] rec_next;
    logic             valid_reg;
    logic             valid_next;

    // The new record goes in front of this one only on a strictly smaller key,
    // so records with equal keys stay in load order. An empty cell counts as
    // larger than any record.
    always_comb
    begin
        lt = !valid_reg
             || (new_rec[REC_W-1:REC_W-KEY_W] < rec_reg[REC_W-1:REC_W-KEY_W]);
    end

    // Next content: rotate towards the head, or insert by shifting right.
    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.rotate)
        begin
            if (valid_reg && !right_valid)
            begin
                // This cell is the tail and receives the old head.
                rec_next   = head_rec;
                valid_next = 1'b1;
            end
            else
            begin
                rec_next   = right_rec;
                valid_next = right_valid;
            end
        end
        else if (ctrl.insert)
        begin
            if (left_lt)
            begin
                rec_next   = left_rec;
                valid_next = left_valid;
            end
            else if (lt)
            begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
    end

    // The valid bit is control state; the record needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

>>> design/rms_chain.sv
// Row of sorting cells, kept in key order from the head at cell 0.
// Depends on rms_pkg and rms_cell.
module rms_chain
    import rms_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_RECORDS,
    parameter int REC_W = DEF_REC_W,
    parameter int KEY_W = DEF_KEY_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [REC_W-1:0] new_rec,
    output logic [REC_W-1:0] head_rec,
    output logic             head_valid
);

    logic [REC_W-1:0] cell_rec   [DEPTH];
    logic             cell_valid [DEPTH];
    logic             cell_lt    [DEPTH];

    // Each cell talks only to its two neighbours, plus the broadcast inputs.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [REC_W-1:0] left_rec;
        logic             left_valid;
        logic             left_lt;
        logic [REC_W-1:0] right_rec;
        logic             right_valid;

        if (i == 0)
        begin : g_first
            assign left_rec   = '0;
            assign left_valid = 1'b0;
            assign left_lt    = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_rec   = cell_rec[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_rec   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_rec   = cell_rec[i+1];
            assign right_valid = cell_valid[i+1];
        end

        rms_cell #(
            .REC_W (REC_W),
            .KEY_W (KEY_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_rec     (new_rec),
            .head_rec    (cell_rec[0]),
            .left_rec    (left_rec),
            .left_valid  (left_valid),
            .left_lt     (left_lt),
            .right_rec   (right_rec),
            .right_valid (right_valid),
            .rec         (cell_rec[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i])
        );
    end

    assign head_rec   = cell_rec[0];
    assign head_valid = cell_valid[0];

endmodule

>>> design/record_merge_sorter.sv
// Record sorter for genomic records, ordered by rank, then name bytes, then
// position, with equal keys kept in load order. Records are sorted as they
// arrive in a row of MAX_RECORDS cells, so a load inserts in place and a read
// takes the head; the row is always in order and there is no sorting pass.
// A read returns the head cell and rotates the row by one place. A load that
// arrives after a partial readout first rotates the row back to its start,
// holding in_stall high while it does so, and then inserts the record if the
// row is not full. Results pass through an output register.
// Depends on rms_pkg, rms_chain, rms_cell and record_merge_sorter_macros.svh.
`include "record_merge_sorter_macros.svh"

module record_merge_sorter
    import rms_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int NAME_BYTES  = DEF_NAME_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Input channel.
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [RANK_W-1:0] chrom_rank,
    input  logic [NAME_W-1:0] chrom_name,
    input  logic [POS_W-1:0]  position,
    // Output channel.
    output logic              out_valid,
    input  logic              out_stall,
    output logic [RANK_W-1:0] out_rank,
    output logic [NAME_W-1:0] out_name,
    output logic [POS_W-1:0]  out_position,
    output logic [IDX_W-1:0]  record_index,
    output logic              is_last,
    output logic              none_left,
    output logic              overflowed
);

    localparam int NAME_BITS = 8 * NAME_BYTES;
    localparam int KEY_W     = RANK_W + NAME_BITS + POS_W;
    localparam int REC_W     = KEY_W + IDX_W;
    localparam int CNT_W     = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_RESTORE = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     rp_reg;
    logic [CNT_W-1:0]     rp_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [KEY_W-1:0]     pend_key_reg;
    logic [KEY_W-1:0]     pend_key_next;
    logic                 pend_ins_reg;
    logic                 pend_ins_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RANK_W-1:0]    out_rank_reg;
    logic [RANK_W-1:0]    out_rank_next;
    logic [NAME_BITS-1:0] out_name_reg;
    logic [NAME_BITS-1:0] out_name_next;
    logic [POS_W-1:0]     out_position_reg;
    logic [POS_W-1:0]     out_position_next;
    logic [IDX_W-1:0]     record_index_reg;
    logic [IDX_W-1:0]     record_index_next;
    logic                 is_last_reg;
    logic                 is_last_next;
    logic                 none_left_reg;
    logic                 none_left_next;
    logic                 overflowed_reg;
    logic                 overflowed_next;

    logic                 in_accept;
    logic                 full;
    logic [KEY_W-1:0]     in_key;
    logic [KEY_W-1:0]     new_key;
    logic [REC_W-1:0]     new_rec;
    logic [REC_W-1:0]     head_rec;
    logic                 head_valid;
    cell_ctrl_t           chain_ctrl;

    // A read needs room in the output register; nothing enters while restoring.
    assign in_stall  = (state_reg != ST_IDLE) || (func && out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign full      = (count_reg == MAX_CNT);

    // Key of an incoming record, name cut to the configured number of bytes.
    assign in_key  = {chrom_rank, chrom_name[NAME_BITS-1:0], position};
    assign new_key = (state_reg == ST_IDLE) ? in_key : pend_key_reg;
    assign new_rec = {new_key, IDX_W'(count_reg)};

    // Sequencing of loads, reads and the rotation back to the start.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rp_next           = rp_reg;
        ovf_next          = ovf_reg;
        pend_key_next     = pend_key_reg;
        pend_ins_next     = pend_ins_reg;
        chain_ctrl        = '0;
        out_valid_next    = out_valid_reg && out_stall;
        out_rank_next     = out_rank_reg;
        out_name_next     = out_name_reg;
        out_position_next = out_position_reg;
        record_index_next = record_index_reg;
        is_last_next      = is_last_reg;
        none_left_next    = none_left_reg;
        overflowed_next   = overflowed_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !func)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (rp_reg != '0 && rp_reg != count_reg)
                    begin
                        // Row is part-way rotated: bring it back first.
                        state_next    = ST_RESTORE;
                        pend_key_next = in_key;
                        pend_ins_next = !full;
                    end
                    else
                    begin
                        rp_next = '0;
                        if (!full)
                        begin
                            chain_ctrl.insert = 1'b1;
                            count_next        = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (in_accept && func)
                begin
                    out_valid_next  = 1'b1;
                    overflowed_next = ovf_reg;
                    if (rp_reg < count_reg)
                    begin
                        chain_ctrl.rotate = 1'b1;
                        rp_next           = rp_reg + CNT_W'(1);
                        out_rank_next     = head_rec[REC_W-1 -: RANK_W];
                        out_name_next     = head_rec[REC_W-RANK_W-1 -: NAME_BITS];
                        out_position_next = head_rec[IDX_W+POS_W-1 -: POS_W];
                        record_index_next = head_rec[IDX_W-1:0];
                        is_last_next      = ((rp_reg + CNT_W'(1)) == count_reg);
                        none_left_next    = 1'b0;
                    end
                    else
                    begin
                        out_rank_next     = '0;
                        out_name_next     = '0;
                        out_position_next = '0;
                        record_index_next = '0;
                        is_last_next      = 1'b0;
                        none_left_next    = 1'b1;
                    end
                end
            end
            ST_RESTORE:
            begin
                if (rp_reg != count_reg)
                begin
                    chain_ctrl.rotate = 1'b1;
                    rp_next           = rp_reg + CNT_W'(1);
                end
                else
                begin
                    // Row is back in order: place the held record, if any.
                    chain_ctrl.insert = pend_ins_reg;
                    if (pend_ins_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    rp_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            ovf_reg       <= 1'b0;
            pend_ins_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            ovf_reg       <= ovf_next;
            pend_ins_reg  <= pend_ins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_key_reg     <= pend_key_next;
        out_rank_reg     <= out_rank_next;
        out_name_reg     <= out_name_next;
        out_position_reg <= out_position_next;
        record_index_reg <= record_index_next;
        is_last_reg      <= is_last_next;
        none_left_reg    <= none_left_next;
        overflowed_reg   <= overflowed_next;
    end

    rms_chain #(
        .DEPTH (MAX_RECORDS),
        .REC_W (REC_W),
        .KEY_W (KEY_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (chain_ctrl),
        .new_rec    (new_rec),
        .head_rec   (head_rec),
        .head_valid (head_valid)
    );

    assign out_valid    = out_valid_reg;
    assign out_rank     = out_rank_reg;
    assign out_name     = NAME_W'(out_name_reg);
    assign out_position = out_position_reg;
    assign record_index = record_index_reg;
    assign is_last      = is_last_reg;
    assign none_left    = none_left_reg;
    assign overflowed   = overflowed_reg;

    // Checks on the sequencing.
    `RMS_ASSERT(a_rp_in_range, rp_reg <= count_reg, "read pointer passed the record count")
    `RMS_ASSERT(a_ctrl_exclusive, !(chain_ctrl.insert && chain_ctrl.rotate), "insert and rotate together")
    `RMS_ASSERT_IMP(a_head_present, (state_reg == ST_IDLE) && (rp_reg < count_reg), head_valid, "head cell empty while records remain")
    `RMS_ASSERT_IMP(a_no_insert_when_full, chain_ctrl.insert, !full, "insert into a full row")
    `RMS_ASSERT_NEXT(a_read_gives_result, in_accept && func, out_valid_reg, "read item without a result")

endmodule
